// ===== src/pls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared widths, command codes and controller/datapath handshake types for
// the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;

  typedef logic        [CMD_W-1:0]  cmd_code_t;
  typedef logic        [POS_W-1:0]  pos_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Command codes on the request channel
  localparam cmd_code_t CMD_LENGTH = 3'd0;
  localparam cmd_code_t CMD_INSERT = 3'd1;
  localparam cmd_code_t CMD_QUERY  = 3'd2;
  localparam cmd_code_t CMD_REMOVE = 3'd3;
  localparam cmd_code_t CMD_DUMP   = 3'd4;

  localparam data_t MISS_VALUE = -32'sd1;

  // Pointer update operations
  typedef logic [2:0] ptr_op_t;
  localparam ptr_op_t PTR_HOLD   = 3'd0;
  localparam ptr_op_t PTR_ZERO   = 3'd1;
  localparam ptr_op_t PTR_POS    = 3'd2;
  localparam ptr_op_t PTR_POS_P1 = 3'd3;
  localparam ptr_op_t PTR_CNT_M1 = 3'd4;
  localparam ptr_op_t PTR_INC    = 3'd5;
  localparam ptr_op_t PTR_DEC    = 3'd6;

  // Output register source select
  typedef logic [1:0] out_src_t;
  localparam out_src_t SRC_RAM   = 2'd0;
  localparam out_src_t SRC_COUNT = 2'd1;
  localparam out_src_t SRC_MISS  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic     load;       // capture request payload
    ptr_op_t  ptr_op;
    logic     rd_en;      // read the store at the next pointer value
    logic     shift;      // this read feeds a move in the cycle after
    logic     shift_up;   // move toward higher addresses
    logic     place;      // write the request value at its position
    logic     count_inc;
    logic     count_dec;
    logic     out_load;
    out_src_t out_src;
    logic     out_last;
  } pls_ctl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_code_t cmd;
    logic      pos_lt_cnt;
    logic      pos_le_cnt;
    logic      pos_last;    // position is the final element
    logic      full;
    logic      cnt_zero;
    logic      ptr_eq_pos;
    logic      ptr_at_end;  // pointer is at the final element
    logic      out_free;
  } pls_sts_t;

endpackage

// ===== src/pls_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_req_if / pls_rsp_if
// Valid/ready channels for list commands and their results.
// ----------------------------------------------------------------------------
interface pls_req_if import pls_pkg::*;;
  logic      valid;
  logic      ready;
  cmd_code_t cmd;
  pos_t      position;
  data_t     value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface pls_rsp_if import pls_pkg::*;;
  logic  valid;
  logic  ready;
  data_t result_value;
  logic  not_found;
  logic  last;

  modport source (output valid, output result_value, output not_found, output last,
                  input ready);
  modport sink   (input valid, input result_value, input not_found, input last,
                  output ready);
endinterface

// ===== src/positional_list_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of up to CAPACITY signed 32-bit values with length, insert,
// query, remove and dump commands.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer (cmd, position, value). rsp returns
//   result transfers (result_value, not_found, last); last marks the final
//   result of a command. Insert and remove return nothing.
//   One command is worked on at a time; req.ready is high only while the
//   sequencer waits for a command.
//   After the transfer a command is decoded. Length, query and an empty
//   dump then answer from the reply or emit state through the output
//   register. Inserts into a full list or past the end, removes past the
//   end and unused codes are dropped at decode. A nonempty dump returns
//   one element per cycle while the result channel does not stall.
//   Insert and remove move one stored element per cycle through the single
//   write port of the element store, reading through its one read port.
//   The output register holds a result until rsp.ready; while it is held,
//   a dump pauses its walk and nothing is dropped.
//   Reset (rst, synchronous) empties the list and drops any held result.
//   The store itself needs no clearing pass: only entries below the count
//   are ever read.
// ----------------------------------------------------------------------------
module positional_list_store_core import pls_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic          clk,
  input logic          rst,
  pls_req_if.sink      req,
  pls_rsp_if.source    rsp
);

  // Command/status bundle between sequencer and datapath
  pls_ctl_t ctl;
  pls_sts_t sts;

  // Sequencer: accepts a command, then steers decode, moves and results
  pls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: store, count, walk pointer and the output register that
  // drives the result channel directly
  pls_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .req_cmd       (req.cmd),
    .req_position  (req.position),
    .req_value     (req.value),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_value     (rsp.result_value),
    .out_not_found (rsp.not_found),
    .out_last      (rsp.last)
  );

endmodule

// ===== src/pls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pls_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_datapath
// Element store, count, walk pointer, move pipeline and output register.
// ----------------------------------------------------------------------------
module pls_datapath import pls_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  pls_ctl_t  ctl,
  output pls_sts_t  sts,
  input  cmd_code_t req_cmd,
  input  pos_t      req_position,
  input  data_t     req_value,
  output logic      out_valid,
  input  logic      out_ready,
  output data_t     out_value,
  output logic      out_not_found,
  output logic      out_last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  cmd_code_t      cmd_reg;
  pos_t           pos_reg;
  data_t          val_reg;
  logic [CW-1:0]  count;
  logic [AW-1:0]  ptr;
  logic [AW-1:0]  ptr_next;
  logic           wr_pend;
  logic           wr_up;
  logic           out_free;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic [POS_W:0] cnt_ext;
  logic [POS_W:0] pos_p1;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_reg <= req_cmd;
      pos_reg <= req_position;
      val_reg <= req_value;
    end
  end

  always_comb begin
    case (ctl.ptr_op)
      PTR_ZERO:   ptr_next = '0;
      PTR_POS:    ptr_next = AW'(pos_reg);
      PTR_POS_P1: ptr_next = AW'(pos_p1);
      PTR_CNT_M1: ptr_next = AW'(count - CW'(1));
      PTR_INC:    ptr_next = ptr + AW'(1);
      PTR_DEC:    ptr_next = ptr - AW'(1);
      default:    ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      wr_pend <= 1'b0;
      wr_up   <= 1'b0;
      count   <= '0;
    end else begin
      ptr     <= ptr_next;
      wr_pend <= ctl.shift;
      wr_up   <= ctl.shift_up;
      if (ctl.count_inc) begin
        count <= count + CW'(1);
      end else if (ctl.count_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  // A pending move writes the word read last cycle next to its source
  assign ram_we    = wr_pend || ctl.place;
  assign ram_waddr = wr_pend ? (wr_up ? ptr + AW'(1) : ptr - AW'(1)) : AW'(pos_reg);
  assign ram_wdata = wr_pend ? ram_rdata : val_reg;

  pls_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.rd_en),
    .raddr (ptr_next),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_last <= ctl.out_last;
      case (ctl.out_src)
        SRC_COUNT: begin
          out_value     <= data_t'(count);
          out_not_found <= 1'b0;
        end
        SRC_MISS: begin
          out_value     <= MISS_VALUE;
          out_not_found <= 1'b1;
        end
        default: begin
          out_value     <= ram_rdata;
          out_not_found <= 1'b0;
        end
      endcase
    end
  end

  assign cnt_ext = (POS_W + 1)'(count);
  assign pos_p1  = {1'b0, pos_reg} + (POS_W + 1)'(1);

  always_comb begin
    sts.cmd        = cmd_reg;
    sts.pos_lt_cnt = {1'b0, pos_reg} < cnt_ext;
    sts.pos_le_cnt = {1'b0, pos_reg} <= cnt_ext;
    sts.pos_last   = pos_p1 == cnt_ext;
    sts.full       = count == CW'(CAPACITY);
    sts.cnt_zero   = count == '0;
    sts.ptr_eq_pos = POS_W'(ptr) == pos_reg;
    sts.ptr_at_end = CW'(ptr) + CW'(1) == count;
    sts.out_free   = out_free;
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) rst |=> (count == '0) && !out_valid)
    else $error("count or output valid not cleared by reset");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("element count beyond capacity");
  a_write_port: assert property (@(posedge clk) disable iff (rst) !(wr_pend && ctl.place))
    else $error("move and place collide on the write port");
  a_move_source: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> $past(ctl.rd_en))
    else $error("move without a preceding read");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> out_free)
    else $error("output register loaded while a result is held");
`endif

endmodule

// ===== src/pls_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ctrl
// Command sequencer: decode, move loops, result emission.
// ----------------------------------------------------------------------------
module pls_ctrl import pls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  pls_sts_t sts,
  output pls_ctl_t ctl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SHIFT_UP = 3'd2;
  localparam logic [2:0] S_PLACE    = 3'd3;
  localparam logic [2:0] S_SHIFT_DN = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;
  localparam logic [2:0] S_REPLY    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign emit_last = (sts.cmd == CMD_QUERY) || sts.ptr_at_end;

  always_comb begin
    ctl        = '0;
    ctl.ptr_op = PTR_HOLD;
    ctl.out_src = SRC_RAM;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (sts.cmd)
          CMD_LENGTH: state_next = S_REPLY;
          CMD_QUERY: begin
            if (sts.pos_lt_cnt) begin
              ctl.ptr_op = PTR_POS;
              ctl.rd_en  = 1'b1;
              state_next = S_EMIT;
            end else begin
              state_next = S_REPLY;
            end
          end
          CMD_DUMP: begin
            if (sts.cnt_zero) begin
              state_next = S_REPLY;
            end else begin
              ctl.ptr_op = PTR_ZERO;
              ctl.rd_en  = 1'b1;
              state_next = S_EMIT;
            end
          end
          CMD_INSERT: begin
            if (!sts.full && sts.pos_le_cnt) begin
              if (sts.pos_lt_cnt) begin
                ctl.ptr_op   = PTR_CNT_M1;
                ctl.rd_en    = 1'b1;
                ctl.shift    = 1'b1;
                ctl.shift_up = 1'b1;
                state_next   = S_SHIFT_UP;
              end else begin
                state_next = S_PLACE;
              end
            end
          end
          CMD_REMOVE: begin
            if (sts.pos_lt_cnt) begin
              if (sts.pos_last) begin
                ctl.count_dec = 1'b1;
              end else begin
                ctl.ptr_op = PTR_POS_P1;
                ctl.rd_en  = 1'b1;
                ctl.shift  = 1'b1;
                state_next = S_SHIFT_DN;
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SHIFT_UP: begin
        if (sts.ptr_eq_pos) begin
          state_next = S_PLACE;
        end else begin
          ctl.ptr_op   = PTR_DEC;
          ctl.rd_en    = 1'b1;
          ctl.shift    = 1'b1;
          ctl.shift_up = 1'b1;
        end
      end
      S_PLACE: begin
        ctl.place     = 1'b1;
        ctl.count_inc = 1'b1;
        state_next    = S_IDLE;
      end
      S_SHIFT_DN: begin
        if (sts.ptr_at_end) begin
          ctl.count_dec = 1'b1;
          state_next    = S_IDLE;
        end else begin
          ctl.ptr_op = PTR_INC;
          ctl.rd_en  = 1'b1;
          ctl.shift  = 1'b1;
        end
      end
      S_EMIT: begin
        ctl.out_last = emit_last;
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          if (emit_last) begin
            state_next = S_IDLE;
          end else begin
            ctl.ptr_op = PTR_INC;
            ctl.rd_en  = 1'b1;
          end
        end
      end
      S_REPLY: begin
        ctl.out_src  = (sts.cmd == CMD_LENGTH) ? SRC_COUNT : SRC_MISS;
        ctl.out_last = 1'b1;
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== bench/tb_positional_list_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_store_core
// Self-checking bench for the positional list store. A short table of
// directed commands covers the empty list, the value extremes, every command
// code and the out-of-range cases. Phases of random commands follow: fill to
// capacity, drain to empty, and mixed traffic. Every result transfer is
// checked field by field against its table row or an in-bench copy of the
// list. Both channels idle at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_positional_list_store_core;
  import pls_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int TOTAL_ITEMS  = 320;
  localparam int DRAIN_CYCLES = CAPACITY + 16;
  localparam int HOLD_TRIGGER = 150;  // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam longint LIMIT_NS = 64'd50_000_000;

  // Command codes the block must ignore
  localparam cmd_code_t CMD_SPARE_5 = 3'd5;
  localparam cmd_code_t CMD_SPARE_6 = 3'd6;
  localparam cmd_code_t CMD_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {PHASE_FILL, PHASE_DRAIN, PHASE_MIX} phase_t;

  typedef struct {
    data_t value;
    logic  not_found;
    logic  last;
  } result_t;

  // One stimulus row; typed rows carry their single result written out
  typedef struct {
    cmd_code_t cmd;
    pos_t      position;
    data_t     value;
    bit        typed;
    data_t     typed_value;
    logic      typed_miss;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pls_req_if req_ch ();
  pls_rsp_if rsp_ch ();

  positional_list_store_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Bench copy of the list and the results it still owes
  data_t     list_cells [CAPACITY];
  int        list_len;
  int        peak_len;
  result_t   pending_results [$];
  stim_row_t directed_rows [$];

  int error_count     = 0;
  int results_checked = 0;
  int items_accepted  = 0;
  int items_ignored   = 0;
  int sender_drains   = 0;
  bit hold_done       = 1'b0;
  bit sender_quiet    = 1'b0;

  // 8 ns period clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit: the slowest legal run is far shorter than this
  initial begin
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // List predictor. Apply one accepted command to the bench copy and, when
  // record is set, queue the results it causes. Return 1 when the command
  // changed the list or produced a result, 0 when the block must ignore it.
  // --------------------------------------------------------------------------
  function automatic bit apply_list_command(input cmd_code_t c, input pos_t p,
                                            input data_t v, input bit record);
    int idx;
    bit acted;
    acted = 1'b0;
    case (c)
      CMD_LENGTH: begin
        if (record) pending_results.push_back(result_t'{data_t'(list_len), 1'b0, 1'b1});
        acted = 1'b1;
      end
      CMD_INSERT: begin
        // Drop inserts into a full list or past the end
        if (list_len < CAPACITY && int'(p) <= list_len) begin
          for (idx = list_len; idx > int'(p); idx--) list_cells[idx] = list_cells[idx-1];
          list_cells[p] = v;
          list_len++;
          if (list_len > peak_len) peak_len = list_len;
          acted = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (record) begin
          if (int'(p) < list_len) pending_results.push_back(result_t'{list_cells[p], 1'b0, 1'b1});
          else pending_results.push_back(result_t'{MISS_VALUE, 1'b1, 1'b1});
        end
        acted = 1'b1;
      end
      CMD_REMOVE: begin
        // Drop removes at or past the end; otherwise close the gap
        if (int'(p) < list_len) begin
          for (idx = int'(p); idx + 1 < list_len; idx++) list_cells[idx] = list_cells[idx+1];
          list_len--;
          acted = 1'b1;
        end
      end
      CMD_DUMP: begin
        if (record) begin
          if (list_len == 0) pending_results.push_back(result_t'{MISS_VALUE, 1'b1, 1'b1});
          for (idx = 0; idx < list_len; idx++)
            pending_results.push_back(result_t'{list_cells[idx], 1'b0,
                                                logic'(idx == list_len - 1)});
        end
        acted = 1'b1;
      end
      default: acted = 1'b0;
    endcase
    return acted;
  endfunction

  // Sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(input cmd_code_t c, input pos_t p, input data_t v,
                         input bit typed, input data_t tv, input logic tm);
    directed_rows.push_back(stim_row_t'{c, p, v, typed, tv, tm});
  endtask

  // --------------------------------------------------------------------------
  // Offer one command on the request channel. Enter and leave at a falling
  // edge; hold valid high across back-to-back transfers. Predict at the
  // transfer edge so the expected results are in command order.
  // --------------------------------------------------------------------------
  task automatic issue_command(input stim_row_t row, output bit acted);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.cmd      = row.cmd;
    req_ch.position = row.position;
    req_ch.value    = row.value;
    do @(posedge clk); while (!req_ch.ready);
    acted = apply_list_command(row.cmd, row.position, row.value, !row.typed);
    if (row.typed) pending_results.push_back(result_t'{row.typed_value, row.typed_miss, 1'b1});
    items_accepted++;
    if (!acted) items_ignored++;
    @(negedge clk);
  endtask

  // Random command shaped by phase: mostly valid positions, some noise
  task automatic draw_command(input phase_t ph, output stim_row_t row);
    int r;
    int c_pick;
    r = $urandom_range(0, 99);
    case (ph)
      PHASE_FILL:  c_pick = (r < 70) ? 1 : (r < 80) ? 2 : (r < 85) ? 0 :
                            (r < 90) ? 4 : (r < 95) ? 3 : 5;
      PHASE_DRAIN: c_pick = (r < 60) ? 3 : (r < 70) ? 1 : (r < 80) ? 2 :
                            (r < 90) ? 4 : (r < 95) ? 0 : 5;
      default:     c_pick = (r < 30) ? 1 : (r < 55) ? 3 : (r < 75) ? 2 :
                            (r < 85) ? 4 : (r < 95) ? 0 : 5;
    endcase
    case (c_pick)
      0:       row.cmd = CMD_LENGTH;
      1:       row.cmd = CMD_INSERT;
      2:       row.cmd = CMD_QUERY;
      3:       row.cmd = CMD_REMOVE;
      4:       row.cmd = CMD_DUMP;
      default: begin
        case ($urandom_range(0, 2))
          0:       row.cmd = CMD_SPARE_5;
          1:       row.cmd = CMD_SPARE_6;
          default: row.cmd = CMD_SPARE_7;
        endcase
      end
    endcase
    // Position: usually in range for the command, sometimes anywhere
    if ($urandom_range(0, 99) < 15) row.position = pos_t'($urandom_range(0, 127));
    else if (row.cmd == CMD_INSERT) row.position = pos_t'($urandom_range(0, list_len));
    else if (list_len > 0) row.position = pos_t'($urandom_range(0, list_len - 1));
    else row.position = '0;
    // Value: full random, with the extremes mixed in
    case ($urandom_range(0, 19))
      0:       row.value = 32'sh7FFF_FFFF;
      1:       row.value = 32'sh8000_0000;
      2:       row.value = MISS_VALUE;
      3:       row.value = '0;
      default: row.value = data_t'($urandom);
    endcase
    row.typed       = 1'b0;
    row.typed_value = '0;
    row.typed_miss  = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, random phases, then drain and report.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t row;
    bit        acted;
    int        counted;
    int        round;
    int        extra;
    int        mixed;
    phase_t    ph;

    req_ch.valid    = 1'b0;
    req_ch.cmd      = CMD_LENGTH;
    req_ch.position = '0;
    req_ch.value    = '0;
    list_len        = 0;
    peak_len        = 0;
    foreach (list_cells[i]) list_cells[i] = '0;

    // Hold reset high, then release it at a falling edge
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty list: length, dump and queries all answer at a glance
    add_row(CMD_LENGTH, 7'd0,   '0, 1'b1, 32'sd0, 1'b0);
    add_row(CMD_DUMP,   7'd0,   '0, 1'b1, MISS_VALUE, 1'b1);
    add_row(CMD_QUERY,  7'd0,   '0, 1'b1, MISS_VALUE, 1'b1);
    add_row(CMD_QUERY,  7'd127, '0, 1'b1, MISS_VALUE, 1'b1);
    add_row(CMD_REMOVE, 7'd0,   '0, 1'b0, '0, 1'b0);             // ignored, empty
    add_row(CMD_INSERT, 7'd1,   32'sd5, 1'b0, '0, 1'b0);         // ignored, past end
    // Build [-1, max, min, 0] from the extremes
    add_row(CMD_INSERT, 7'd0,   32'sh7FFF_FFFF, 1'b0, '0, 1'b0);
    add_row(CMD_INSERT, 7'd1,   32'sh8000_0000, 1'b0, '0, 1'b0);
    add_row(CMD_INSERT, 7'd0,   MISS_VALUE, 1'b0, '0, 1'b0);
    add_row(CMD_INSERT, 7'd4,   32'sd7, 1'b0, '0, 1'b0);         // ignored, past end
    add_row(CMD_INSERT, 7'd3,   '0, 1'b0, '0, 1'b0);             // append at count
    add_row(CMD_LENGTH, 7'd0,   '0, 1'b1, 32'sd4, 1'b0);
    add_row(CMD_QUERY,  7'd0,   '0, 1'b1, MISS_VALUE, 1'b0);     // stored -1 is found
    add_row(CMD_QUERY,  7'd3,   '0, 1'b0, '0, 1'b0);
    add_row(CMD_QUERY,  7'd4,   '0, 1'b1, MISS_VALUE, 1'b1);
    add_row(CMD_DUMP,   7'd0,   '0, 1'b0, '0, 1'b0);
    add_row(CMD_REMOVE, 7'd127, '0, 1'b0, '0, 1'b0);             // ignored, past end
    add_row(CMD_REMOVE, 7'd3,   '0, 1'b0, '0, 1'b0);             // drop tail
    add_row(CMD_REMOVE, 7'd0,   '0, 1'b0, '0, 1'b0);             // drop head
    add_row(CMD_SPARE_5, 7'd127, MISS_VALUE, 1'b0, '0, 1'b0);
    add_row(CMD_SPARE_6, 7'd0,   32'sh5555_5555, 1'b0, '0, 1'b0);
    add_row(CMD_SPARE_7, 7'h55,  32'shAAAA_AAAA, 1'b0, '0, 1'b0);
    add_row(CMD_DUMP,   7'd0,   '0, 1'b0, '0, 1'b0);
    add_row(CMD_LENGTH, 7'd0,   '0, 1'b1, 32'sd2, 1'b0);

    foreach (directed_rows[i]) issue_command(directed_rows[i], acted);

    // Random phases: fill to capacity (and knock on the full list), drain to
    // empty, then mixed traffic; repeat until the item budget is spent
    counted = directed_rows.size();
    round   = 0;
    while (counted < TOTAL_ITEMS) begin
      ph           = (round % 3 == 0) ? PHASE_FILL : (round % 3 == 1) ? PHASE_DRAIN : PHASE_MIX;
      sender_quiet = ($urandom_range(0, 3) == 0);
      extra        = 6;
      mixed        = 0;
      while (counted < TOTAL_ITEMS &&
             ((ph == PHASE_FILL  && (list_len < CAPACITY || extra > 0)) ||
              (ph == PHASE_DRAIN && list_len > 0) ||
              (ph == PHASE_MIX   && mixed < 50))) begin
        if (ph == PHASE_FILL && list_len == CAPACITY) extra--;
        mixed++;
        draw_command(ph, row);
        issue_command(row, acted);
        counted++;
      end
      // After a fill, stop offering until every owed result is back
      if (ph == PHASE_FILL) begin
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        sender_drains++;
      end
      round++;
    end
    req_ch.valid = 1'b0;

    // Wait for the last results, then give the block time to misbehave
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d commands accepted, %0d ignored, %0d results checked",
             items_accepted, items_ignored, results_checked);
    $display("Summary: peak length %0d of %0d, long hold-off %0s, %0d sender drains",
             peak_len, CAPACITY, hold_done ? "done" : "missed", sender_drains);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: drive ready at the falling edge. Work in windows, some with no
  // stalls at all; otherwise stall now and then, mostly short.
  // Once, with the sender still offering, hold off for a long stretch so the
  // output register fills and the request channel backs up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int window_left;
    bit quiet;
    stall_left    = 0;
    window_left   = 0;
    quiet         = 1'b0;
    rsp_ch.ready  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && results_checked >= HOLD_TRIGGER && req_ch.valid) begin
        hold_done    = 1'b1;
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (window_left == 0) begin
        window_left = 64;
        quiet       = ($urandom_range(0, 3) == 0);
      end
      window_left--;
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        stall_left   = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
                                                    : $urandom_range(1, 3);
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
      end
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: at each result transfer, compare against the oldest
  // owed result. Flag results nobody asked for.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t owed;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: value %0d not_found %b last %b",
                 $time, rsp_ch.result_value, rsp_ch.not_found, rsp_ch.last);
        error_count++;
      end else begin
        owed = pending_results.pop_front();
        if (rsp_ch.result_value !== owed.value) begin
          $display("%0t: result_value mismatch: expected %0d, actual %0d",
                   $time, owed.value, rsp_ch.result_value);
          error_count++;
        end
        if (rsp_ch.not_found !== owed.not_found) begin
          $display("%0t: not_found mismatch: expected %b, actual %b",
                   $time, owed.not_found, rsp_ch.not_found);
          error_count++;
        end
        if (rsp_ch.last !== owed.last) begin
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, owed.last, rsp_ch.last);
          error_count++;
        end
      end
    end
  end

endmodule

// ===== files.f =====
src/pls_pkg.sv
src/pls_if.sv
src/pls_ram.sv
src/pls_datapath.sv
src/pls_ctrl.sv
src/positional_list_store_core.sv
bench/tb_positional_list_store_core.sv
